// ===== hdl/mbb_pkg.sv =====
`default_nettype none
package mbb_pkg;

  localparam int MAX_ROW_BYTES = 32;
  localparam int MAX_ROWS      = 128;
  localparam int STORE_SIZE    = MAX_ROW_BYTES * MAX_ROWS;
  localparam int ADDR_W        = $clog2(STORE_SIZE);
  localparam int ROW_W         = $clog2(MAX_ROWS);

  // item opcodes
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_DATA  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_WRITE = 2'd3;

  // blit modes
  localparam logic [1:0] MODE_OVERLAY = 2'd0;
  localparam logic [1:0] MODE_ERASE   = 2'd1;
  localparam logic [1:0] MODE_ALPHA   = 2'd2;
  localparam logic [1:0] MODE_ALT_OR  = 2'd3;

  // configuration register indexes
  localparam logic [0:0] REG_ROW_BYTES = 1'd0;
  localparam logic [0:0] REG_ROW_COUNT = 1'd1;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  pos_x;
    logic [7:0]  pos_y;
    logic [7:0]  width_px;
    logic [7:0]  line_count;
    logic [1:0]  blit_mode;
    logic [7:0]  pixel_byte;
    logic [7:0]  alpha_byte;
    logic [11:0] fb_address;
    logic [7:0]  fb_write_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       blit_active;
  } out_item_t;

  // effective geometry after saturation
  typedef struct packed {
    logic [5:0] rb;
    logic [7:0] rc;
  } geom_t;

  typedef enum logic [2:0] {
    K_START = 3'd0,
    K_SKIP  = 3'd1,
    K_DATA  = 3'd2,
    K_READ  = 3'd3,
    K_WRITE = 3'd4
  } kind_t;

  // classified item as queued between front and back
  typedef struct packed {
    kind_t       kind;
    logic [1:0]  mode;
    logic [2:0]  shift;
    logic [4:0]  colb;
    logic [5:0]  bpr;
    logic [3:0]  tail;
    logic [7:0]  lines;
    logic        act;
    logic [7:0]  pos_y;
    logic [7:0]  pixel;
    logic [7:0]  alpha;
    logic [11:0] addr;
    logic [7:0]  wval;
  } q_item_t;

  typedef struct packed {
    logic    valid;
    q_item_t item;
  } q_head_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } back_stat_t;

endpackage
`default_nettype wire

// ===== hdl/mbb_front.sv =====
`default_nettype none
module mbb_front
  import mbb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire geom_t      geom,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire in_item_t   in_data,
  input  wire back_stat_t bstat,
  output q_head_t         head
);

  q_item_t    q_mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       acc;
  logic       pop;
  q_item_t    cls;
  logic [8:0] wsum;

  assign in_stall = (cnt_r == 2'd2) || bstat.clearing;
  assign acc      = in_valid && !in_stall;
  assign pop      = bstat.pop && (cnt_r != 2'd0);

  // classify and precompute start parameters
  always_comb begin
    wsum          = {1'b0, in_data.width_px} + 9'd7;
    cls           = '0;
    cls.shift     = in_data.pos_x[2:0];
    cls.colb      = in_data.pos_x[7:3];
    cls.bpr       = wsum[8:3];
    cls.tail      = (in_data.width_px[2:0] != 3'd0) ? {1'b0, in_data.width_px[2:0]} : 4'd8;
    cls.lines     = in_data.line_count;
    cls.act       = (wsum[8:3] != 6'd0) && (in_data.line_count != 8'd0);
    cls.mode      = (in_data.blit_mode == MODE_ALT_OR) ? MODE_OVERLAY : in_data.blit_mode;
    cls.pos_y     = in_data.pos_y;
    cls.pixel     = in_data.pixel_byte;
    cls.alpha     = in_data.alpha_byte;
    cls.addr      = in_data.fb_address;
    cls.wval      = in_data.fb_write_value;
    unique case (in_data.op)
      OP_START: cls.kind = ({1'b0, in_data.pos_x[7:3]} >= geom.rb) ? K_SKIP : K_START;
      OP_DATA:  cls.kind = K_DATA;
      OP_READ:  cls.kind = K_READ;
      OP_WRITE: cls.kind = K_WRITE;
      default:  cls.kind = K_SKIP;
    endcase
  end

  always_comb begin
    wr_ptr_nxt = acc ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, acc} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      q_mem_r[wr_ptr_r] <= cls;
    end
  end

  assign head.valid = (cnt_r != 2'd0);
  assign head.item  = q_mem_r[rd_ptr_r];

endmodule
`default_nettype wire

// ===== hdl/mbb_mod.sv =====
`default_nettype none
module mbb_mod
  import mbb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire logic [7:0] dividend,
  input  wire logic [7:0] divisor,
  output logic            done,
  output logic [7:0]      rem
);

  logic       busy_r, busy_nxt;
  logic       done_r, done_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic [7:0] rem_r, rem_nxt;
  logic [7:0] dvd_r, dvd_nxt;
  logic [7:0] div_r, div_nxt;
  logic [8:0] trial;
  logic [8:0] diff;

  // restoring remainder, one dividend bit per cycle
  always_comb begin
    trial    = {rem_r, dvd_r[7]};
    diff     = trial - {1'b0, div_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    div_nxt  = div_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 3'd0;
      rem_nxt  = 8'd0;
      dvd_nxt  = dividend;
      div_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = (trial >= {1'b0, div_r}) ? diff[7:0] : trial[7:0];
      dvd_nxt = {dvd_r[6:0], 1'b0};
      cnt_nxt = cnt_r + 3'd1;
      if (cnt_r == 3'd7) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 3'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    div_r <= div_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule
`default_nettype wire

// ===== hdl/mbb_back.sv =====
`default_nettype none
module mbb_back
  import mbb_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire geom_t   geom,
  input  wire q_head_t head,
  output back_stat_t   bstat,
  input  wire logic    res_take,
  output logic         res_valid,
  output out_item_t    res
);

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_MOD    = 8'b0000_0100,
    S_ISSUE  = 8'b0000_1000,
    S_MERGE1 = 8'b0001_0000,
    S_RD2    = 8'b0010_0000,
    S_MERGE2 = 8'b0100_0000,
    S_READ   = 8'b1000_0000
  } state_t;

  typedef enum logic [2:0] {
    T_Y   = 3'b001,
    T_ROW = 3'b010,
    T_COL = 3'b100
  } tgt_t;

  state_t            state_r, state_nxt;
  tgt_t              tgt_r, tgt_nxt;
  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic              active_r, active_nxt;
  logic [1:0]        mode_r, mode_nxt;
  logic [2:0]        shift_r, shift_nxt;
  logic [4:0]        colb_r, colb_nxt;
  logic [5:0]        bpr_r, bpr_nxt;
  logic [3:0]        tail_r, tail_nxt;
  logic [7:0]        lines_r, lines_nxt;
  logic [ROW_W-1:0]  cur_row_r, cur_row_nxt;
  logic [5:0]        bir_r, bir_nxt;
  logic [7:0]        con_r, con_nxt;
  logic [7:0]        coff_r, coff_nxt;
  logic [7:0]        pix_r, pix_nxt;
  logic [7:0]        alp_r, alp_nxt;
  logic [ROW_W-1:0]  wrow_r, wrow_nxt;
  logic [6:0]        wcol_r, wcol_nxt;
  logic [ADDR_W-1:0] base_r, base_nxt;
  logic              need_col_r, need_col_nxt;
  logic              res_valid_r, res_valid_nxt;
  out_item_t         res_r, res_nxt;

  // frame store, single port, read-first
  logic [7:0]        mem [STORE_SIZE];
  logic [7:0]        mem_rd_r;
  logic [ADDR_W-1:0] mem_addr;
  logic              mem_we;
  logic [7:0]        mem_wd;

  logic              mod_start;
  logic [7:0]        mod_dvd;
  logic [7:0]        mod_div;
  logic              mod_done;
  logic [7:0]        mod_rem;

  logic              pop;
  logic              clip;
  logic [6:0]        col0;
  logic              need_row;
  logic              need_col;
  logic [ROW_W-1:0]  mul_row;
  logic [6:0]        mul_col;
  logic [12:0]       prod;
  logic [ADDR_W-1:0] addr_calc;
  logic [ADDR_W-1:0] addr_w;
  logic              last;
  logic [7:0]        tmask;
  logic [7:0]        b;
  logic [7:0]        a;
  logic [7:0]        on;
  logic [7:0]        off;
  logic [15:0]       on_sh;
  logic [15:0]       off_sh;
  logic              drop;
  logic [6:0]        col2;
  logic [7:0]        row_inc;
  logic [7:0]        lines_dec;

  function automatic logic [7:0] tail_mask(input logic [3:0] t);
    logic [7:0] m;
    if (t >= 4'd1 && t <= 4'd8) begin
      m = 8'hff << (4'd8 - t);
    end else begin
      m = 8'hff;
    end
    return m;
  endfunction

  mbb_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (mod_dvd),
    .divisor  (mod_div),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  assign pop = (state_r == S_IDLE) && head.valid && (!res_valid_r || res_take);

  // datapath terms
  always_comb begin
    clip      = (mode_r == MODE_ALPHA);
    col0      = {2'b00, colb_r} + {1'b0, bir_r};
    need_row  = ({1'b0, cur_row_r} >= geom.rc);
    need_col  = !clip && (col0 >= {1'b0, geom.rb});
    mul_row   = (state_r == S_ISSUE) ? wrow_r : cur_row_r;
    mul_col   = (state_r == S_ISSUE) ? wcol_r : col0;
    prod      = {6'd0, mul_row} * {7'd0, geom.rb};
    addr_calc = prod[ADDR_W-1:0] + {{(ADDR_W-7){1'b0}}, mul_col};
    addr_w    = base_r + {{(ADDR_W-7){1'b0}}, wcol_r};
    last      = ({1'b0, bir_r} + 7'd1) >= {1'b0, bpr_r};
    tmask     = last ? tail_mask(tail_r) : 8'hff;
    b         = pix_r & tmask;
    a         = (clip ? alp_r : 8'hff) & tmask;
    case (mode_r)
      MODE_ERASE: begin
        on  = 8'h00;
        off = b;
      end
      MODE_ALPHA: begin
        on  = b & a;
        off = ~b & a;
      end
      default: begin
        on  = b;
        off = 8'h00;
      end
    endcase
    // upper byte lands in this column, lower byte spills to the next
    on_sh     = {on, 8'h00} >> shift_r;
    off_sh    = {off, 8'h00} >> shift_r;
    drop      = clip && (wcol_r >= {1'b0, geom.rb});
    col2      = wcol_r + 7'd1;
    if (!clip && (col2 == {1'b0, geom.rb})) begin
      col2 = 7'd0;
    end
    row_inc   = {1'b0, wrow_r} + 8'd1;
    lines_dec = lines_r - 8'd1;
  end

  always_comb begin
    state_nxt     = state_r;
    tgt_nxt       = tgt_r;
    clr_cnt_nxt   = clr_cnt_r;
    active_nxt    = active_r;
    mode_nxt      = mode_r;
    shift_nxt     = shift_r;
    colb_nxt      = colb_r;
    bpr_nxt       = bpr_r;
    tail_nxt      = tail_r;
    lines_nxt     = lines_r;
    cur_row_nxt   = cur_row_r;
    bir_nxt       = bir_r;
    con_nxt       = con_r;
    coff_nxt      = coff_r;
    pix_nxt       = pix_r;
    alp_nxt       = alp_r;
    wrow_nxt      = wrow_r;
    wcol_nxt      = wcol_r;
    base_nxt      = base_r;
    need_col_nxt  = need_col_r;
    res_valid_nxt = res_take ? 1'b0 : res_valid_r;
    res_nxt       = res_r;
    mem_addr      = addr_calc;
    mem_we        = 1'b0;
    mem_wd        = 8'h00;
    mod_start     = 1'b0;
    mod_dvd       = {1'b0, cur_row_r};
    mod_div       = geom.rc;

    unique case (state_r)
      S_CLEAR: begin
        mem_addr    = clr_cnt_r;
        mem_we      = 1'b1;
        clr_cnt_nxt = clr_cnt_r + {{(ADDR_W-1){1'b0}}, 1'b1};
        if (clr_cnt_r == ADDR_W'(STORE_SIZE - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (pop) begin
          unique case (head.item.kind)
            K_WRITE: begin
              mem_addr      = head.item.addr;
              mem_we        = 1'b1;
              mem_wd        = head.item.wval;
              res_valid_nxt = 1'b1;
              res_nxt       = '{read_data: 8'h00, blit_active: active_r};
            end
            K_READ: begin
              mem_addr  = head.item.addr;
              state_nxt = S_READ;
            end
            K_START: begin
              mode_nxt   = head.item.mode;
              shift_nxt  = head.item.shift;
              colb_nxt   = head.item.colb;
              bpr_nxt    = head.item.bpr;
              tail_nxt   = head.item.tail;
              lines_nxt  = head.item.lines;
              bir_nxt    = 6'd0;
              con_nxt    = 8'h00;
              coff_nxt   = 8'h00;
              active_nxt = head.item.act;
              if (head.item.pos_y < geom.rc) begin
                cur_row_nxt   = head.item.pos_y[ROW_W-1:0];
                res_valid_nxt = 1'b1;
                res_nxt       = '{read_data: 8'h00, blit_active: head.item.act};
              end else begin
                mod_start = 1'b1;
                mod_dvd   = head.item.pos_y;
                tgt_nxt   = T_Y;
                state_nxt = S_MOD;
              end
            end
            K_DATA: begin
              if (!active_r) begin
                res_valid_nxt = 1'b1;
                res_nxt       = '{read_data: 8'h00, blit_active: 1'b0};
              end else begin
                pix_nxt      = head.item.pixel;
                alp_nxt      = head.item.alpha;
                wrow_nxt     = cur_row_r;
                wcol_nxt     = col0;
                need_col_nxt = need_col;
                if (need_row) begin
                  mod_start = 1'b1;
                  tgt_nxt   = T_ROW;
                  state_nxt = S_MOD;
                end else if (need_col) begin
                  mod_start = 1'b1;
                  mod_dvd   = {1'b0, col0};
                  mod_div   = {2'b00, geom.rb};
                  tgt_nxt   = T_COL;
                  state_nxt = S_MOD;
                end else begin
                  base_nxt  = prod[ADDR_W-1:0];
                  state_nxt = S_MERGE1;
                end
              end
            end
            default: begin
              // start beyond the row is dropped
              res_valid_nxt = 1'b1;
              res_nxt       = '{read_data: 8'h00, blit_active: active_r};
            end
          endcase
        end
      end

      S_MOD: begin
        if (mod_done) begin
          unique case (tgt_r)
            T_Y: begin
              cur_row_nxt   = mod_rem[ROW_W-1:0];
              res_valid_nxt = 1'b1;
              res_nxt       = '{read_data: 8'h00, blit_active: active_r};
              state_nxt     = S_IDLE;
            end
            T_ROW: begin
              wrow_nxt = mod_rem[ROW_W-1:0];
              if (need_col_r) begin
                mod_start = 1'b1;
                mod_dvd   = {1'b0, wcol_r};
                mod_div   = {2'b00, geom.rb};
                tgt_nxt   = T_COL;
              end else begin
                state_nxt = S_ISSUE;
              end
            end
            T_COL: begin
              wcol_nxt  = mod_rem[6:0];
              state_nxt = S_ISSUE;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end

      S_ISSUE: begin
        base_nxt  = prod[ADDR_W-1:0];
        state_nxt = S_MERGE1;
      end

      S_MERGE1: begin
        mem_addr = addr_w;
        mem_we   = !drop;
        mem_wd   = (mem_rd_r | on_sh[15:8] | con_r) & ~(off_sh[15:8] | coff_r);
        con_nxt  = on_sh[7:0];
        coff_nxt = off_sh[7:0];
        if (!last) begin
          bir_nxt       = bir_r + 6'd1;
          res_valid_nxt = 1'b1;
          res_nxt       = '{read_data: 8'h00, blit_active: active_r};
          state_nxt     = S_IDLE;
        end else begin
          wcol_nxt  = col2;
          state_nxt = S_RD2;
        end
      end

      S_RD2: begin
        mem_addr  = addr_w;
        state_nxt = S_MERGE2;
      end

      S_MERGE2: begin
        // flush the spill bits into the column after the row's last byte
        mem_addr      = addr_w;
        mem_we        = !drop;
        mem_wd        = (mem_rd_r | con_r) & ~coff_r;
        con_nxt       = 8'h00;
        coff_nxt      = 8'h00;
        bir_nxt       = 6'd0;
        cur_row_nxt   = (row_inc == geom.rc) ? '0 : row_inc[ROW_W-1:0];
        lines_nxt     = lines_dec;
        active_nxt    = (lines_dec != 8'd0);
        res_valid_nxt = 1'b1;
        res_nxt       = '{read_data: 8'h00, blit_active: (lines_dec != 8'd0)};
        state_nxt     = S_IDLE;
      end

      S_READ: begin
        res_valid_nxt = 1'b1;
        res_nxt       = '{read_data: mem_rd_r, blit_active: active_r};
        state_nxt     = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      tgt_r       <= T_Y;
      clr_cnt_r   <= '0;
      active_r    <= 1'b0;
      mode_r      <= MODE_OVERLAY;
      shift_r     <= 3'd0;
      colb_r      <= 5'd0;
      bpr_r       <= 6'd0;
      tail_r      <= 4'd0;
      lines_r     <= 8'd0;
      cur_row_r   <= '0;
      bir_r       <= 6'd0;
      con_r       <= 8'h00;
      coff_r      <= 8'h00;
      need_col_r  <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tgt_r       <= tgt_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      active_r    <= active_nxt;
      mode_r      <= mode_nxt;
      shift_r     <= shift_nxt;
      colb_r      <= colb_nxt;
      bpr_r       <= bpr_nxt;
      tail_r      <= tail_nxt;
      lines_r     <= lines_nxt;
      cur_row_r   <= cur_row_nxt;
      bir_r       <= bir_nxt;
      con_r       <= con_nxt;
      coff_r      <= coff_nxt;
      need_col_r  <= need_col_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pix_r  <= pix_nxt;
    alp_r  <= alp_nxt;
    wrow_r <= wrow_nxt;
    wcol_r <= wcol_nxt;
    base_r <= base_nxt;
    res_r  <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wd;
    end
    mem_rd_r <= mem[mem_addr];
  end

  assign bstat.pop      = pop;
  assign bstat.clearing = (state_r == S_CLEAR);
  assign res_valid      = res_valid_r;
  assign res            = res_r;

endmodule
`default_nettype wire

// ===== hdl/mono_bitmap_blitter_top.sv =====
// flow: the front queues up to two items while the back works on one; a result
//   goes from the back's result register through the output register
// data bytes: each is a single-port read-modify-write of the store, the last
//   byte of a line a second one for its spill; a wrap adds a bit-serial remainder
// reset: synchronous active low; afterwards a clear pass zeroes the frame
//   store with in_stall high, configuration writes are taken throughout
`default_nettype none
module mono_bitmap_blitter_top
  import mbb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  // configuration
  input  wire logic       cfg_we,
  input  wire logic [0:0] cfg_index,
  input  wire logic [7:0] cfg_wdata,
  // item input
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire in_item_t   in_data,
  // result output
  output logic            out_valid,
  input  wire logic       out_stall,
  output out_item_t       out_data
);

  logic [5:0] row_bytes_r, row_bytes_nxt;
  logic [7:0] row_count_r, row_count_nxt;
  geom_t      geom;
  q_head_t    head;
  back_stat_t bstat;
  logic       res_valid;
  out_item_t  res;
  logic       res_take;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_data_r;

  // register writes
  always_comb begin
    row_bytes_nxt = row_bytes_r;
    row_count_nxt = row_count_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_ROW_BYTES: row_bytes_nxt = cfg_wdata[5:0];
        REG_ROW_COUNT: row_count_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_bytes_r <= 6'd16;
      row_count_r <= 8'd96;
    end else begin
      row_bytes_r <= row_bytes_nxt;
      row_count_r <= row_count_nxt;
    end
  end

  // saturate geometry into what the store can hold
  always_comb begin
    if (row_bytes_r == 6'd0) begin
      geom.rb = 6'd1;
    end else if ({1'b0, row_bytes_r} > 7'(MAX_ROW_BYTES)) begin
      geom.rb = 6'(MAX_ROW_BYTES);
    end else begin
      geom.rb = row_bytes_r;
    end
    if (row_count_r == 8'd0) begin
      geom.rc = 8'd1;
    end else if ({1'b0, row_count_r} > 9'(MAX_ROWS)) begin
      geom.rc = 8'(MAX_ROWS);
    end else begin
      geom.rc = row_count_r;
    end
  end

  // front: accepts and classifies items into a two-entry queue
  mbb_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .geom     (geom),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .bstat    (bstat),
    .head     (head)
  );

  // back: runs blits and store accesses, holds one finished result
  mbb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .geom      (geom),
    .head      (head),
    .bstat     (bstat),
    .res_take  (res_take),
    .res_valid (res_valid),
    .res       (res)
  );

  // output register: takes the back's result whenever it is empty or draining
  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// ===== hdl/mbb_checker.sv =====
`default_nettype none
module mbb_props
  import mbb_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_data
);

  logic [3:0] pend_r, pend_nxt;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // items taken but not yet returned
  always_comb begin
    pend_nxt = pend_r + {3'd0, in_acc} - {3'd0, out_acc};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 4'd0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  a_clear_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> in_stall)
    else $error("input taken while store clear pending");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pend_r != 4'd0))
    else $error("result with no outstanding item");

  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= 4'd5)
    else $error("more items in flight than buffering allows");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind mono_bitmap_blitter_top mbb_props u_mbb_props (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire

// ===== verif/mbb_checker.sv =====
module mbb_checker
  import mbb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  input  logic       in_stall,
  input  in_item_t   in_data,
  input  logic       out_valid,
  input  logic       out_stall,
  input  out_item_t  out_data,
  output int         mismatch_count,
  output int         owed_count
);

  // shadow framebuffer and geometry
  logic [7:0] frame_mem [STORE_SIZE];
  logic [5:0] rb_cfg;
  logic [7:0] rc_cfg;

  // running blit
  logic       blit_on;
  logic [1:0] blit_mode_q;
  logic [2:0] pix_shift;
  logic [7:0] bytes_per_line;
  logic [3:0] tail_len;
  logic [7:0] lines_left;
  logic [7:0] line_row;
  logic [7:0] byte_pos;
  logic [7:0] first_col;
  logic [7:0] spill_on;
  logic [7:0] spill_off;

  out_item_t owed_results [$];

  function automatic int eff_row_bytes();
    if (rb_cfg < 1) return 1;
    if (rb_cfg > MAX_ROW_BYTES) return MAX_ROW_BYTES;
    return rb_cfg;
  endfunction

  function automatic int eff_row_count();
    if (rc_cfg < 1) return 1;
    if (rc_cfg > MAX_ROWS) return MAX_ROWS;
    return rc_cfg;
  endfunction

  function automatic void merge_bits(int row, int col, logic [7:0] on, logic [7:0] off);
    int idx;
    idx = row * eff_row_bytes() + col;
    if (idx < STORE_SIZE) frame_mem[idx] = (frame_mem[idx] | on) & ~off;
  endfunction

  // apply one item to the shadow state, return the result it owes
  function automatic out_item_t paint_item(in_item_t it);
    out_item_t  res;
    int         rbv, rcv, r, row, col;
    logic [7:0] b, a, on, off;
    logic [31:0] mask;
    bit         last, clip;
    rbv = eff_row_bytes();
    rcv = eff_row_count();
    res.read_data = 8'h00;
    case (it.op)
      OP_START: begin
        // start past the row edge leaves everything alone
        if (int'(it.pos_x >> 3) < rbv) begin
          blit_mode_q    = (it.blit_mode == MODE_ALT_OR) ? MODE_OVERLAY : it.blit_mode;
          pix_shift      = it.pos_x[2:0];
          first_col      = it.pos_x >> 3;
          bytes_per_line = 8'((int'(it.width_px) + 7) >> 3);
          tail_len       = (it.width_px[2:0] != 3'd0) ? {1'b0, it.width_px[2:0]} : 4'd8;
          lines_left     = it.line_count;
          line_row       = 8'(int'(it.pos_y) % rcv);
          byte_pos       = 8'd0;
          spill_on       = 8'h00;
          spill_off      = 8'h00;
          blit_on        = (bytes_per_line != 8'd0) && (lines_left != 8'd0);
        end
      end
      OP_DATA: begin
        if (blit_on) begin
          b    = it.pixel_byte;
          a    = (blit_mode_q == MODE_ALPHA) ? it.alpha_byte : 8'hff;
          clip = (blit_mode_q == MODE_ALPHA);
          last = (int'(byte_pos) + 1 >= int'(bytes_per_line));
          r    = pix_shift;
          if (last) begin
            // drop padding bits past the bitmap width
            mask = 32'hff << (8 - int'(tail_len));
            b &= mask[7:0];
            a &= mask[7:0];
          end
          case (blit_mode_q)
            MODE_ERASE: begin
              on  = 8'h00;
              off = b;
            end
            MODE_ALPHA: begin
              on  = b & a;
              off = ~b & a;
            end
            default: begin
              on  = b;
              off = 8'h00;
            end
          endcase
          row = int'(line_row) % rcv;
          col = int'(first_col) + int'(byte_pos);
          if (!clip) col = col % rbv;
          if (!(clip && col >= rbv))
            merge_bits(row, col, (on >> r) | spill_on, (off >> r) | spill_off);
          if (r != 0) begin
            spill_on  = on << (8 - r);
            spill_off = off << (8 - r);
          end else begin
            spill_on  = 8'h00;
            spill_off = 8'h00;
          end
          if (!last) begin
            byte_pos = byte_pos + 8'd1;
          end else begin
            // flush the spill into the byte after the line
            col = col + 1;
            if (!clip) col = col % rbv;
            if (!(clip && col >= rbv)) merge_bits(row, col, spill_on, spill_off);
            spill_on   = 8'h00;
            spill_off  = 8'h00;
            byte_pos   = 8'd0;
            line_row   = 8'((row + 1) % rcv);
            lines_left = lines_left - 8'd1;
            if (lines_left == 8'd0) blit_on = 1'b0;
          end
        end
      end
      OP_READ: begin
        res.read_data = frame_mem[it.fb_address];
      end
      OP_WRITE: begin
        frame_mem[it.fb_address] = it.fb_write_value;
      end
    endcase
    res.blit_active = blit_on;
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      for (int i = 0; i < STORE_SIZE; i++) frame_mem[i] = 8'h00;
      rb_cfg         = 6'd16;
      rc_cfg         = 8'd96;
      blit_on        = 1'b0;
      blit_mode_q    = MODE_OVERLAY;
      pix_shift      = 3'd0;
      bytes_per_line = 8'd0;
      tail_len       = 4'd0;
      lines_left     = 8'd0;
      line_row       = 8'd0;
      byte_pos       = 8'd0;
      first_col      = 8'd0;
      spill_on       = 8'h00;
      spill_off      = 8'h00;
      owed_results.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_ROW_BYTES) rb_cfg = cfg_wdata[5:0];
        else if (cfg_index == REG_ROW_COUNT) rc_cfg = cfg_wdata;
      end
      if (in_valid && !in_stall) owed_results.push_back(paint_item(in_data));
      if (out_valid && !out_stall) begin
        if (owed_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result: read_data %02h blit_active %0d",
                     out_data.read_data, out_data.blit_active);
        end else begin
          want = owed_results.pop_front();
          if (out_data.read_data !== want.read_data ||
              out_data.blit_active !== want.blit_active) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: read_data exp %02h got %02h, blit_active exp %0d got %0d",
                       want.read_data, out_data.read_data,
                       want.blit_active, out_data.blit_active);
          end
        end
      end
    end
    owed_count = owed_results.size();
  end

endmodule

// ===== verif/tb_mono_bitmap_blitter_top.sv =====
module tb_mono_bitmap_blitter_top;
  import mbb_pkg::*;

  // slowest run: clear pass, then each item waiting out a long gap on the
  // sender, a long stall on the receiver and its own handling in the block
  localparam int CYCLE_LIMIT = 1000000;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [0:0] cfg_index;
  logic [7:0] cfg_wdata;
  logic       in_valid;
  logic       in_stall;
  in_item_t   in_data;
  logic       out_valid;
  logic       out_stall;
  out_item_t  out_data;

  int mismatch_count;
  int owed_count;
  int sent_items;

  // quiet stretches: no idling on that side
  bit quiet_in;
  bit quiet_out;

  mono_bitmap_blitter_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // watches both channels and the register port, predicts and compares
  mbb_checker u_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .mismatch_count (mismatch_count),
    .owed_count     (owed_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("** mono_bitmap_blitter_top: FAILED **");
    $finish;
  end

  // idle length: mostly short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // receiver backpressure, changes on the falling edge only
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= 1'b0;
        if (!quiet_out && $urandom_range(0, 99) < 30) hold_left = pick_gap();
      end
    end
  end

  // all fields random, caller overrides what matters
  function automatic in_item_t noise_item();
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    return raw[$bits(in_item_t)-1:0];
  endfunction

  // bytes biased toward all-clear and all-set
  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 8'h00;
    if (r < 30) return 8'hff;
    return 8'($urandom);
  endfunction

  // called at a falling edge, returns at the falling edge after the accept
  task automatic push_item(input in_item_t it);
    int gap;
    gap = (!quiet_in && $urandom_range(0, 99) < 35) ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_start(input logic [7:0] x, input logic [7:0] y, input logic [7:0] w,
                            input logic [7:0] n, input logic [1:0] mode);
    in_item_t it;
    it            = noise_item();
    it.op         = OP_START;
    it.pos_x      = x;
    it.pos_y      = y;
    it.width_px   = w;
    it.line_count = n;
    it.blit_mode  = mode;
    push_item(it);
    sent_items++;
  endtask

  task automatic send_data(input logic [7:0] pix, input logic [7:0] alpha);
    in_item_t it;
    it            = noise_item();
    it.op         = OP_DATA;
    it.pixel_byte = pix;
    it.alpha_byte = alpha;
    push_item(it);
    sent_items++;
  endtask

  task automatic send_read(input logic [11:0] addr);
    in_item_t it;
    it            = noise_item();
    it.op         = OP_READ;
    it.fb_address = addr;
    push_item(it);
    sent_items++;
  endtask

  task automatic send_write(input logic [11:0] addr, input logic [7:0] val);
    in_item_t it;
    it                = noise_item();
    it.op             = OP_WRITE;
    it.fb_address     = addr;
    it.fb_write_value = val;
    push_item(it);
    sent_items++;
  endtask

  // drop valid, let every result drain, then allow the block to settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (owed_count != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // both registers back to back, only while the block is quiet
  task automatic set_geometry(input logic [7:0] rb_val, input logic [7:0] rc_val);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_ROW_BYTES;
    cfg_wdata <= rb_val;
    @(negedge clk);
    cfg_index <= REG_ROW_COUNT;
    cfg_wdata <= rc_val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // framebuffer byte inside or just past the blit footprint
  function automatic logic [11:0] near_addr(int x, int y, int n, int bpr, int erb, int erc);
    int row, col;
    row = (y % erc + $urandom_range(0, n)) % erc;
    col = ((x >> 3) + $urandom_range(0, bpr)) % erb;
    return 12'(row * erb + col);
  endfunction

  // one blit with random geometry and content, reads afterwards to check it
  task automatic random_blit(input int erb, input int erc);
    int x, y, w, n, bpr, total, count, r;
    logic [1:0] mode;
    bit took;
    in_item_t stray;
    x = ($urandom_range(0, 99) < 85) ? $urandom_range(0, erb * 8 - 1) : $urandom_range(0, 255);
    y = $urandom_range(0, 255);
    r = $urandom_range(0, 99);
    if (r < 80) w = $urandom_range(1, 24);
    else if (r < 92) w = $urandom_range(25, 255);
    else if (r < 96) w = 0;
    else w = 255;
    r = $urandom_range(0, 99);
    if (w > 64) n = $urandom_range(1, 2);
    else if (r < 85) n = $urandom_range(1, 4);
    else if (r < 95) n = $urandom_range(5, 40);
    else if (r < 97) n = 0;
    else n = (w <= 8) ? 255 : 3;
    mode  = 2'($urandom_range(0, 3));
    bpr   = (w + 7) >> 3;
    took  = (x >> 3) < erb;
    total = bpr * n;
    // busy background so erase and alpha have bits to clear
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 6)) send_write(near_addr(x, y, n, bpr, erb, erc), pick_byte());
    send_start(8'(x), 8'(y), 8'(w), 8'(n), mode);
    if (!took || total == 0) begin
      // stray data: ignored, or feeds a blit left running before
      repeat ($urandom_range(0, 2)) begin
        stray    = noise_item();
        stray.op = OP_DATA;
        push_item(stray);
      end
    end else begin
      // sometimes abandon the blit early
      count = ($urandom_range(0, 99) < 8) ? $urandom_range(0, total - 1) : total;
      for (int k = 0; k < count; k++) begin
        send_data(pick_byte(), pick_byte());
        if ($urandom_range(0, 9) == 0) begin
          if ($urandom_range(0, 1) == 0) send_read(near_addr(x, y, n, bpr, erb, erc));
          else send_write(near_addr(x, y, n, bpr, erb, erc), pick_byte());
        end
      end
    end
    repeat ($urandom_range(1, 4)) send_read(near_addr(x, y, n, bpr, erb, erc));
  endtask

  initial begin
    logic [7:0] rb_val, rc_val;
    int erb, erc, target, r;
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = REG_ROW_BYTES;
    cfg_wdata  = 8'h00;
    in_valid   = 1'b0;
    in_data    = '0;
    quiet_in   = 1'b0;
    quiet_out  = 1'b0;
    sent_items = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // directed part, reset geometry 16 x 96
    // store extremes: lowest and highest address, an all-one value
    send_write(12'h000, 8'ha5);
    send_read(12'h000);
    send_write(12'hfff, 8'hff);
    send_read(12'hfff);
    // overlay with shift 3, 12-pixel width so the last byte carries padding
    send_start(8'd3, 8'd0, 8'd12, 8'd2, MODE_OVERLAY);
    send_data(8'hff, 8'h00);
    send_data(8'hff, 8'h00);
    send_data(8'h80, 8'hff);
    send_data(8'h01, 8'hff);
    send_read(12'd0);
    send_read(12'd1);
    send_read(12'd16);
    // erase over a preset byte, line 255 wraps to row 63
    send_write(12'(63 * 16), 8'h5a);
    send_start(8'd0, 8'd255, 8'd8, 8'd1, MODE_ERASE);
    send_data(8'hff, 8'h00);
    send_read(12'(63 * 16));
    // alpha at the last column: spill is clipped at the row edge
    send_start(8'd125, 8'd200, 8'd16, 8'd1, MODE_ALPHA);
    send_data(8'hff, 8'hff);
    send_data(8'h00, 8'hf0);
    send_read(12'(8 * 16 + 15));
    // mode three acts as overlay, widest and tallest bitmap
    send_start(8'd0, 8'd1, 8'd255, 8'd255, MODE_ALT_OR);
    send_data(8'h00, 8'h00);
    // start past the row is ignored, blit keeps running
    send_start(8'd255, 8'd7, 8'd8, 8'd1, MODE_ERASE);
    send_data(8'haa, 8'h55);
    // zero width is taken but leaves no blit, data is then ignored
    send_start(8'd8, 8'd2, 8'd0, 8'd3, MODE_OVERLAY);
    send_data(8'hff, 8'hff);
    // zero lines, same outcome
    send_start(8'd8, 8'd2, 8'd8, 8'd0, MODE_ALPHA);
    send_read(12'd16);

    // random part, one phase per geometry, extremes included
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin
          rb_val = 8'd1;
          rc_val = 8'd1;
        end
        1: begin
          rb_val = 8'd32;
          rc_val = 8'd128;
        end
        2: begin
          // beyond range, saturates to the maximum
          rb_val = 8'd63;
          rc_val = 8'd255;
        end
        3: begin
          // zero saturates to one
          rb_val = 8'd0;
          rc_val = 8'd0;
        end
        4: begin
          rb_val = 8'd16;
          rc_val = 8'd96;
        end
        default: begin
          rb_val = 8'($urandom_range(0, 63));
          rc_val = 8'($urandom_range(0, 255));
        end
      endcase
      set_geometry(rb_val, rc_val);
      erb    = (rb_val == 0) ? 1 : (rb_val > MAX_ROW_BYTES) ? MAX_ROW_BYTES : rb_val;
      erc    = (rc_val == 0) ? 1 : (rc_val > MAX_ROWS) ? MAX_ROWS : rc_val;
      target = sent_items + 100;
      while (sent_items < target) begin
        if ($urandom_range(0, 9) == 0) begin
          quiet_in  = ($urandom_range(0, 3) == 0);
          quiet_out = ($urandom_range(0, 3) == 0);
        end
        r = $urandom_range(0, 99);
        if (r < 8) push_item(noise_item());
        else if (r < 11) send_read(12'($urandom_range(0, 4095)));
        else if (r < 14) send_write(12'($urandom_range(0, 4095)), pick_byte());
        else random_blit(erb, erc);
      end
    end

    // drain and settle before the verdict
    wait_idle();
    repeat (20) @(negedge clk);
    if (mismatch_count == 0 && owed_count == 0) begin
      $display("** mono_bitmap_blitter_top: PASSED **");
    end else begin
      $display("** mono_bitmap_blitter_top: FAILED **");
    end
    $finish;
  end

endmodule

// ===== mono_bitmap_blitter_top.f =====
hdl/mbb_pkg.sv
hdl/mbb_front.sv
hdl/mbb_mod.sv
hdl/mbb_back.sv
hdl/mono_bitmap_blitter_top.sv
hdl/mbb_checker.sv
verif/mbb_checker.sv
verif/tb_mono_bitmap_blitter_top.sv
